FILE: rtl/utwc_pkg.sv
package utwc_pkg;

  localparam int DEPTH        = 64;
  localparam int COORD_BITS   = 16;
  localparam int PAYLOAD_BITS = 32;

  localparam int ADDR_W  = $clog2(DEPTH);
  // count runs to DEPTH, cursor to DEPTH + 1
  localparam int CNT_W   = $clog2(DEPTH + 2);
  localparam int KEY_W   = 3 * COORD_BITS;
  localparam int ENTRY_W = KEY_W + PAYLOAD_BITS;

  typedef enum logic [2:0] {
    MODE_CLEAR,
    MODE_INSERT,
    MODE_FIND,
    MODE_DELETE,
    MODE_RETRIEVE,
    MODE_FIRST,
    MODE_NEXT,
    MODE_LAST
  } mode_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_FULL,
    ERR_EMPTY,
    ERR_BOUNDS
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_RET_RD,
    ST_RET_WR,
    ST_RESP
  } state_t;

endpackage

FILE: rtl/utwc_if.sv
interface utwc_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [2:0]                        mode;
  logic [utwc_pkg::COORD_BITS-1:0]   key_x;
  logic [utwc_pkg::COORD_BITS-1:0]   key_y;
  logic [utwc_pkg::COORD_BITS-1:0]   key_z;
  logic [utwc_pkg::PAYLOAD_BITS-1:0] payload;

  modport source (output valid, mode, key_x, key_y, key_z, payload, input ready);
  modport sink   (input valid, mode, key_x, key_y, key_z, payload, output ready);
endinterface

interface utwc_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic [utwc_pkg::COORD_BITS-1:0]   out_key_x;
  logic [utwc_pkg::COORD_BITS-1:0]   out_key_y;
  logic [utwc_pkg::COORD_BITS-1:0]   out_key_z;
  logic [utwc_pkg::PAYLOAD_BITS-1:0] out_payload;
  logic [utwc_pkg::CNT_W-1:0]        count;
  logic [utwc_pkg::CNT_W-1:0]        cursor;
  logic                              is_empty;
  logic                              is_full;
  logic                              at_end;
  logic [1:0]                        error;

  modport source (output valid, found, out_key_x, out_key_y, out_key_z, out_payload,
                  count, cursor, is_empty, is_full, at_end, error, input ready);
  modport sink   (input valid, found, out_key_x, out_key_y, out_key_z, out_payload,
                  count, cursor, is_empty, is_full, at_end, error, output ready);
endinterface

FILE: rtl/utwc_ram.sv
module utwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/utwc_cmp.sv
module utwc_cmp (
  input  logic                       valid,
  input  logic [utwc_pkg::KEY_W-1:0] probe,
  input  logic [utwc_pkg::KEY_W-1:0] stored,
  output logic                       hit
);

  // full three-coordinate key match, only on a slot that was really read
  assign hit = valid && (probe == stored);

endmodule

FILE: rtl/unsorted_table_with_cursor.sv
// Clear, insert, first, next, last and a refused delete or retrieve go from idle straight to
// the result state; a delete or retrieve that goes ahead passes through a read and a write state.
// Find reads the keys one slot per cycle from slot 0 and stops at the lowest hit or after the
// last live entry; on an empty table it goes straight to the result state.
// One transaction at a time: the next is taken the cycle after the result is taken. Reset
// (synchronous, rst high) returns to idle, empties the table and zeroes the cursor.
module unsorted_table_with_cursor (
  input  logic        clk,
  input  logic        rst,
  utwc_cmd_if.sink    cmd,
  utwc_rsp_if.source  rsp
);

  localparam int ADDR_W  = utwc_pkg::ADDR_W;
  localparam int CNT_W   = utwc_pkg::CNT_W;
  localparam int KEY_W   = utwc_pkg::KEY_W;
  localparam int ENTRY_W = utwc_pkg::ENTRY_W;
  localparam int CB      = utwc_pkg::COORD_BITS;
  localparam int PB      = utwc_pkg::PAYLOAD_BITS;

  utwc_pkg::state_t state, state_next;
  utwc_pkg::mode_t  mode;

  // Table status registers
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] cursor;

  // Probe key held for the whole scan
  logic [KEY_W-1:0] key;

  // Scan pointers: scan_idx is the next slot to read, cmp_idx the slot whose
  // data sits on the memory output this cycle
  logic [CNT_W-1:0] scan_idx;
  logic [CNT_W-1:0] cmp_idx;
  logic             cmp_valid;

  // Result registers
  logic               res_found;
  logic [KEY_W-1:0]   res_key;
  logic [PB-1:0]      res_payload;
  utwc_pkg::err_t     res_err;

  // Memory port
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic             accept;
  logic             empty;
  logic             full;
  logic             cur_in;
  logic [CNT_W-1:0] last_idx;
  logic             scan_rd;
  logic             scan_last;
  logic             hit;

  assign accept    = cmd.valid && cmd.ready;
  assign mode      = utwc_pkg::mode_t'(cmd.mode);
  assign empty     = (count == '0);
  assign full      = (count == CNT_W'(utwc_pkg::DEPTH));
  assign cur_in    = (cursor < count);
  assign last_idx  = count - CNT_W'(1);
  assign scan_rd   = (scan_idx < count);
  // Slot under compare is the last live one: a miss ends the scan here
  assign scan_last = cmp_valid && ((cmp_idx + CNT_W'(1)) == count);

  // Entry layout: {x, y, z, payload}
  utwc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (utwc_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Single key comparator, one slot per cycle
  utwc_cmp u_cmp (
    .valid  (cmp_valid && (state == utwc_pkg::ST_SCAN)),
    .probe  (key),
    .stored (ram_rdata[ENTRY_W-1 -: KEY_W]),
    .hit    (hit)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      utwc_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          case (mode)
            utwc_pkg::MODE_FIND: begin
              state_next = empty ? utwc_pkg::ST_RESP : utwc_pkg::ST_SCAN;
            end
            utwc_pkg::MODE_DELETE: begin
              state_next = (empty || !cur_in) ? utwc_pkg::ST_RESP : utwc_pkg::ST_DEL_RD;
            end
            utwc_pkg::MODE_RETRIEVE: begin
              state_next = (empty || !cur_in) ? utwc_pkg::ST_RESP : utwc_pkg::ST_RET_RD;
            end
            default: begin
              state_next = utwc_pkg::ST_RESP;
            end
          endcase
        end
      end
      utwc_pkg::ST_SCAN: begin
        if (hit || scan_last) begin
          state_next = utwc_pkg::ST_RESP;
        end
      end
      utwc_pkg::ST_DEL_RD: state_next = utwc_pkg::ST_DEL_WR;
      utwc_pkg::ST_DEL_WR: state_next = utwc_pkg::ST_RESP;
      utwc_pkg::ST_RET_RD: state_next = utwc_pkg::ST_RET_WR;
      utwc_pkg::ST_RET_WR: state_next = utwc_pkg::ST_RESP;
      utwc_pkg::ST_RESP: begin
        if (rsp.ready) begin
          state_next = utwc_pkg::ST_IDLE;
        end
      end
      default: state_next = utwc_pkg::ST_IDLE;
    endcase
  end

  // Handshake and memory port per state
  always_comb begin
    cmd.ready = 1'b0;
    rsp.valid = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = count[ADDR_W-1:0];
    ram_wdata = {cmd.key_x, cmd.key_y, cmd.key_z, cmd.payload};
    ram_re    = 1'b0;
    ram_raddr = scan_idx[ADDR_W-1:0];
    case (state)
      utwc_pkg::ST_IDLE: begin
        cmd.ready = 1'b1;
        // append goes straight into the slot after the last entry
        ram_we    = cmd.valid && (mode == utwc_pkg::MODE_INSERT) && !full;
      end
      utwc_pkg::ST_SCAN: begin
        ram_re = scan_rd;
      end
      utwc_pkg::ST_DEL_RD: begin
        ram_re    = 1'b1;
        ram_raddr = last_idx[ADDR_W-1:0];
      end
      utwc_pkg::ST_DEL_WR: begin
        // move the last entry into the hole at the cursor
        ram_we    = 1'b1;
        ram_waddr = cursor[ADDR_W-1:0];
        ram_wdata = ram_rdata;
      end
      utwc_pkg::ST_RET_RD: begin
        ram_re    = 1'b1;
        ram_raddr = cursor[ADDR_W-1:0];
      end
      utwc_pkg::ST_RESP: begin
        rsp.valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Datapath and status registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= utwc_pkg::ST_IDLE;
      count     <= '0;
      cursor    <= '0;
      scan_idx  <= '0;
      cmp_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        utwc_pkg::ST_IDLE: begin
          if (cmd.valid) begin
            key         <= {cmd.key_x, cmd.key_y, cmd.key_z};
            res_found   <= 1'b0;
            res_key     <= '0;
            res_payload <= '0;
            res_err     <= utwc_pkg::ERR_NONE;
            scan_idx    <= '0;
            cmp_valid   <= 1'b0;
            case (mode)
              utwc_pkg::MODE_CLEAR: begin
                count  <= '0;
                cursor <= '0;
              end
              utwc_pkg::MODE_INSERT: begin
                if (full) begin
                  res_err <= utwc_pkg::ERR_FULL;
                end else begin
                  count <= count + CNT_W'(1);
                end
              end
              utwc_pkg::MODE_FIND: begin
                // empty table: miss at once, cursor to count
                if (empty) begin
                  cursor <= count;
                end
              end
              utwc_pkg::MODE_DELETE, utwc_pkg::MODE_RETRIEVE: begin
                if (empty) begin
                  res_err <= utwc_pkg::ERR_EMPTY;
                end else if (!cur_in) begin
                  res_err <= utwc_pkg::ERR_BOUNDS;
                end
              end
              utwc_pkg::MODE_FIRST: begin
                cursor <= '0;
              end
              utwc_pkg::MODE_NEXT: begin
                // from count the cursor may step once more, past that it is refused
                if (cursor > count) begin
                  res_err <= utwc_pkg::ERR_BOUNDS;
                end else begin
                  cursor <= cursor + CNT_W'(1);
                end
              end
              utwc_pkg::MODE_LAST: begin
                if (empty) begin
                  res_err <= utwc_pkg::ERR_EMPTY;
                end else begin
                  cursor <= last_idx;
                end
              end
              default: begin
              end
            endcase
          end
        end
        utwc_pkg::ST_SCAN: begin
          cmp_valid <= scan_rd;
          cmp_idx   <= scan_idx;
          if (scan_rd) begin
            scan_idx <= scan_idx + CNT_W'(1);
          end
          // lowest matching slot wins; a miss parks the cursor at count
          if (hit) begin
            cursor    <= cmp_idx;
            res_found <= 1'b1;
          end else if (scan_last) begin
            cursor <= count;
          end
        end
        utwc_pkg::ST_DEL_WR: begin
          count <= last_idx;
        end
        utwc_pkg::ST_RET_WR: begin
          res_key     <= ram_rdata[ENTRY_W-1 -: KEY_W];
          res_payload <= ram_rdata[PB-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Result transaction: status is read live from the table registers, which
  // hold still while the result waits
  assign rsp.found       = res_found;
  assign rsp.out_key_x   = res_key[KEY_W-1 -: CB];
  assign rsp.out_key_y   = res_key[KEY_W-CB-1 -: CB];
  assign rsp.out_key_z   = res_key[CB-1:0];
  assign rsp.out_payload = res_payload;
  assign rsp.count       = count;
  assign rsp.cursor      = cursor;
  assign rsp.is_empty    = empty;
  assign rsp.is_full     = full;
  assign rsp.at_end      = !cur_in;
  assign rsp.error       = res_err;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(utwc_pkg::DEPTH))
    else $error("entry count beyond table depth");

  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    cursor <= count + CNT_W'(1))
    else $error("cursor more than one past the count");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == utwc_pkg::ST_SCAN) |-> (scan_idx <= count))
    else $error("scan ran past the live entries");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !cmd.ready)
    else $error("new command taken while one is in progress");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == utwc_pkg::ST_DEL_WR) |=> (count == $past(count) - CNT_W'(1)))
    else $error("delete did not drop the count by one");
`endif

endmodule
